FILE: rtl/linear_probe_hash_table_core_assert.svh
// Assertion macros shared by the checker.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 64;

    localparam int REQ_W     = 2;
    localparam int KEY_W     = 32;
    localparam int HASH_W    = 32;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int MAX_OCC_W = 8;

    localparam logic [MAX_OCC_W-1:0] MAX_OCC_RESET = 8'd192;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET   = 2'd0,
        REQ_SET   = 2'd1,
        REQ_DEL   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        RSP_DONE   = 2'd0,
        RSP_ABSENT = 2'd1,
        RSP_FULL   = 2'd2
    } rsp_status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_TOMB  = 2'd1,
        SLOT_LIVE  = 2'd2
    } slot_status_t;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_PROBE,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  key_hash;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_new_key;
        logic [VALUE_W-1:0]  value_out;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/lpht_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_slot_store #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int KEY_STORE  = lpht_pkg::KEY_W,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
    output logic      [1:0]                  rd_status,
    output logic      [KEY_STORE-1:0]        rd_key,
    output logic      [VALUE_BITS-1:0]       rd_value,
    input  wire logic                        st_we,
    input  wire logic                        dt_we,
    input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  wire logic [1:0]                  wr_status,
    input  wire logic [KEY_STORE-1:0]        wr_key,
    input  wire logic [VALUE_BITS-1:0]       wr_value
);

    logic [1:0]                      status_mem [CAPACITY];
    logic [KEY_STORE+VALUE_BITS-1:0] data_mem   [CAPACITY];
    logic [KEY_STORE+VALUE_BITS-1:0] data_q;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            status_mem[wr_addr] <= wr_status;
        end
        rd_status <= status_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dt_we)
        begin
            data_mem[wr_addr] <= {wr_key, wr_value};
        end
        data_q <= data_mem[rd_addr];
    end

    assign rd_key   = data_q[KEY_STORE+VALUE_BITS-1:VALUE_BITS];
    assign rd_value = data_q[VALUE_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/linear_probe_hash_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing hash table with linear probing and tombstones. A request is
// taken when start is high and busy is low. Get, set and delete walk the slot
// store from the home slot (key_hash mod CAPACITY), one slot per cycle through
// the registered-read slot memory, with busy high while they probe. Clear, and
// the sweep that follows reset, rewrite the status memory one slot per cycle,
// busy all the while. Each request gives one result, shown on rsp with done
// high for exactly one cycle, the first cycle with busy low again; the receiver
// cannot stall it, so it must take every result as it appears. A new request
// may be started in that same cycle. The user must write max_occupied through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce it.

module linear_probe_hash_table_core #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire lpht_pkg::req_t                    req,
    output logic                                   done,
    output lpht_pkg::rsp_t                         rsp,
    input  wire logic                              cfg_we,
    input  wire logic [lpht_pkg::MAX_OCC_W-1:0]    cfg_wdata
);

    import lpht_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int KS = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CW = (AW + 2 > MAX_OCC_W) ? AW + 2 : MAX_OCC_W;

    state_t state_reg, state_next;

    req_t                   req_reg;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          cnt_reg;
    logic                   tomb_vld_reg;
    logic [AW-1:0]          tomb_idx_reg;
    logic [AW:0]            used_reg, used_next;
    logic [MAX_OCC_W-1:0]   max_reg;
    logic                   done_reg, done_next;
    rsp_t                   rsp_reg, rsp_next;

    logic [AW-1:0]          rd_addr;
    logic [1:0]             rd_status;
    logic [KS-1:0]          rd_key;
    logic [VALUE_BITS-1:0]  rd_value;
    logic                   st_we, dt_we;
    logic [AW-1:0]          wr_addr;
    logic [1:0]             wr_status;

    logic                   is_empty, is_tomb, key_hit, last, stop, tomb_first;
    logic                   tgt_vld, tgt_empty, over_limit;
    logic [AW-1:0]          tgt_idx;

    lpht_slot_store #(
        .CAPACITY   (CAPACITY),
        .KEY_STORE  (KS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .rd_status (rd_status),
        .rd_key    (rd_key),
        .rd_value  (rd_value),
        .st_we     (st_we),
        .dt_we     (dt_we),
        .wr_addr   (wr_addr),
        .wr_status (wr_status),
        .wr_key    (req_reg.key[KS-1:0]),
        .wr_value  (req_reg.value[VALUE_BITS-1:0])
    );

    // probe evaluation of the slot read last cycle
    always_comb
    begin
        is_empty   = (rd_status == SLOT_EMPTY);
        is_tomb    = (rd_status == SLOT_TOMB);
        key_hit    = (rd_status == SLOT_LIVE) && (rd_key == req_reg.key[KS-1:0]);
        last       = &cnt_reg;
        stop       = is_empty || key_hit || last;
        tomb_first = is_tomb && !tomb_vld_reg;
        tgt_vld    = 1'b0;
        tgt_empty  = 1'b0;
        tgt_idx    = idx_reg;
        if (tomb_vld_reg)
        begin
            tgt_vld = 1'b1;
            tgt_idx = tomb_idx_reg;
        end
        else if (tomb_first)
        begin
            tgt_vld = 1'b1;
        end
        else if (is_empty)
        begin
            tgt_vld   = 1'b1;
            tgt_empty = 1'b1;
        end
        over_limit = tgt_empty && ((CW'(used_reg) + CW'(1)) > CW'(max_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (&idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (req.req_type == REQ_CLEAR) ? S_CLEAR : S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (stop)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (&idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        rd_addr   = idx_reg + AW'(1);
        st_we     = 1'b0;
        dt_we     = 1'b0;
        wr_addr   = idx_reg;
        wr_status = SLOT_EMPTY;
        used_next = used_reg;
        done_next = 1'b0;
        rsp_next  = '0;
        case (state_reg)
            S_INIT:
            begin
                st_we = 1'b1;
            end
            S_IDLE:
            begin
                rd_addr = req.key_hash[AW-1:0];
            end
            S_PROBE:
            begin
                if (stop)
                begin
                    done_next = 1'b1;
                    case (req_reg.req_type)
                        REQ_GET:
                        begin
                            if (key_hit)
                            begin
                                rsp_next.value_out = VALUE_W'(rd_value);
                            end
                            else
                            begin
                                rsp_next.status = RSP_ABSENT;
                            end
                        end
                        REQ_SET:
                        begin
                            if (key_hit)
                            begin
                                dt_we = 1'b1;
                            end
                            else if (!tgt_vld || over_limit)
                            begin
                                rsp_next.status = RSP_FULL;
                            end
                            else
                            begin
                                st_we               = 1'b1;
                                dt_we               = 1'b1;
                                wr_addr             = tgt_idx;
                                wr_status           = SLOT_LIVE;
                                rsp_next.is_new_key = 1'b1;
                                if (tgt_empty)
                                begin
                                    used_next = used_reg + (AW+1)'(1);
                                end
                            end
                        end
                        REQ_DEL:
                        begin
                            if (key_hit)
                            begin
                                st_we     = 1'b1;
                                wr_status = SLOT_TOMB;
                            end
                            else
                            begin
                                rsp_next.status = RSP_ABSENT;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = RSP_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                st_we     = 1'b1;
                used_next = '0;
                done_next = &idx_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            tomb_vld_reg <= 1'b0;
            tomb_idx_reg <= '0;
            used_reg     <= '0;
            max_reg      <= MAX_OCC_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg      <= (req.req_type == REQ_CLEAR) ? '0
                                                                     : req.key_hash[AW-1:0];
                        cnt_reg      <= '0;
                        tomb_vld_reg <= 1'b0;
                    end
                end
                S_PROBE:
                begin
                    if (!stop)
                    begin
                        idx_reg <= idx_reg + AW'(1);
                        cnt_reg <= cnt_reg + AW'(1);
                        if (tomb_first)
                        begin
                            tomb_vld_reg <= 1'b1;
                            tomb_idx_reg <= idx_reg;
                        end
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/lpht_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "linear_probe_hash_table_core_assert.svh"

module lpht_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire lpht_pkg::rsp_t rsp
);

    import lpht_pkg::*;

    `LPHT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "transfer did not raise busy")
    `LPHT_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "result shown while busy")
    `LPHT_ASSERT_IMP(a_status_code, clk, rst_n, done, (rsp.status == RSP_DONE) || (rsp.status == RSP_ABSENT) || (rsp.status == RSP_FULL), "bad status code")
    `LPHT_ASSERT_IMP(a_new_done, clk, rst_n, done && rsp.is_new_key, rsp.status == RSP_DONE, "new key without done status")
    `LPHT_ASSERT_IMP(a_value_zero, clk, rst_n, done && (rsp.status != RSP_DONE), rsp.value_out == '0, "value on failed request")

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

FILE: test/tb_linear_probe_hash_table_core.sv
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_core;
    import lpht_pkg::*;

    localparam int SLOTS = CAPACITY_DEF;
    localparam int POOL_MAX = 320;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req_in = '0;
    logic done;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [MAX_OCC_W-1:0] cfg_wdata = '0;

    // table model
    slot_status_t tbl_st [SLOTS];
    logic [KEY_W-1:0] tbl_key [SLOTS];
    logic [VALUE_W-1:0] tbl_val [SLOTS];
    int used_m = 0;
    logic [MAX_OCC_W-1:0] max_occ_m = MAX_OCC_RESET;

    req_t req_backlog [$];
    rsp_t rsp_due [$];
    logic took = 1'b0;
    int gap_left = 0;
    bit calm = 1'b0;

    logic [KEY_W-1:0] pool_key [POOL_MAX];
    logic [HASH_W-1:0] pool_hash [POOL_MAX];

    int errors = 0;
    int n_sent = 0;
    int n_done = 0;
    int n_absent = 0;
    int n_full = 0;
    int n_new = 0;
    int n_cfg = 0;

    linear_probe_hash_table_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req_in),
        .done(done),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_st[i] = SLOT_EMPTY;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
    end

    // Walk from the home slot; hit is the key's slot, else first tombstone,
    // else the stopping empty slot, else -1.
    function automatic bit find_slot(input logic [KEY_W-1:0] k, input logic [HASH_W-1:0] h,
                                     output int hit);
        int home;
        int idx;
        int tomb;
        int i;
        home = int'(h % SLOTS);
        tomb = -1;
        hit = -1;
        for (i = 0; i < SLOTS; i++)
        begin
            idx = (home + i) % SLOTS;
            if (tbl_st[idx] == SLOT_EMPTY)
            begin
                hit = (tomb >= 0) ? tomb : idx;
                return 1'b0;
            end
            if (tbl_st[idx] == SLOT_TOMB)
            begin
                if (tomb < 0)
                    tomb = idx;
            end
            else if (tbl_key[idx] == k)
            begin
                hit = idx;
                return 1'b1;
            end
        end
        hit = tomb;
        return 1'b0;
    endfunction

    function automatic rsp_t predict_rsp(input req_t r);
        rsp_t e;
        int hit;
        bit found;
        e = '0;
        e.status = RSP_DONE;
        case (req_kind_t'(r.req_type))
            REQ_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    tbl_st[i] = SLOT_EMPTY;
                used_m = 0;
            end
            REQ_SET:
            begin
                found = find_slot(r.key, r.key_hash, hit);
                if (found)
                    tbl_val[hit] = r.value;
                else if (hit < 0)
                    e.status = RSP_FULL;
                else if (tbl_st[hit] == SLOT_EMPTY && used_m + 1 > int'(max_occ_m))
                    e.status = RSP_FULL;
                else
                begin
                    if (tbl_st[hit] == SLOT_EMPTY)
                        used_m++;
                    tbl_st[hit] = SLOT_LIVE;
                    tbl_key[hit] = r.key;
                    tbl_val[hit] = r.value;
                    e.is_new_key = 1'b1;
                end
            end
            default:
            begin
                if (used_m == 0)
                    e.status = RSP_ABSENT;
                else
                begin
                    found = find_slot(r.key, r.key_hash, hit);
                    if (!found)
                        e.status = RSP_ABSENT;
                    else if (req_kind_t'(r.req_type) == REQ_GET)
                        e.value_out = tbl_val[hit];
                    else
                        tbl_st[hit] = SLOT_TOMB;
                end
            end
        endcase
        return e;
    endfunction

    task automatic flag_field(input string what, input logic [63:0] want, input logic [63:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
    endtask

    // monitor: check results, then record the transfer of this edge
    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
            took <= 1'b0;
        else
        begin
            if (cfg_we)
                max_occ_m = cfg_wdata;
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result at %0t: %h", $time, rsp);
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.status !== want.status)
                        flag_field("status", 64'(want.status), 64'(rsp.status));
                    if (rsp.is_new_key !== want.is_new_key)
                        flag_field("is_new_key", 64'(want.is_new_key), 64'(rsp.is_new_key));
                    if (rsp.value_out !== want.value_out)
                        flag_field("value_out", want.value_out, rsp.value_out);
                    case (rsp_status_t'(want.status))
                        RSP_DONE: n_done++;
                        RSP_ABSENT: n_absent++;
                        default: n_full++;
                    endcase
                    if (want.is_new_key)
                        n_new++;
                end
            end
            if (start && !busy)
            begin
                rsp_due.push_back(predict_rsp(req_in));
                n_sent++;
            end
            took <= start && !busy;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (req_backlog.size() > 0)
            begin
                req_in <= req_backlog.pop_front();
                start <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 4);
            end
            else
                start <= 1'b0;
        end
    end

    task automatic add_req(input req_kind_t kind, input logic [KEY_W-1:0] k,
                           input logic [HASH_W-1:0] h, input logic [VALUE_W-1:0] v);
        req_t r;
        r.req_type = kind;
        r.key = k;
        r.key_hash = h;
        r.value = v;
        req_backlog.push_back(r);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || start || rsp_due.size() != 0 || busy);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [MAX_OCC_W-1:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(negedge clk);
        n_cfg++;
    endtask

    task automatic random_phase(input int n_items);
        int pool_n;
        int spread;
        int base;
        int pick;
        int r;
        req_kind_t kind;
        logic [KEY_W-1:0] k;
        logic [HASH_W-1:0] h;
        pool_n = $urandom_range(4, POOL_MAX);
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 7;
            2: spread = 31;
            default: spread = 255;
        endcase
        base = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < pool_n; i++)
        begin
            pool_key[i] = $urandom;
            pool_hash[i] = $urandom;
            pool_hash[i][7:0] = 8'(base + $urandom_range(0, spread));
        end
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 1)
                kind = REQ_CLEAR;
            else if (r < 50)
                kind = REQ_SET;
            else if (r < 75)
                kind = REQ_GET;
            else
                kind = REQ_DEL;
            pick = $urandom_range(0, pool_n - 1);
            k = pool_key[pick];
            h = pool_hash[pick];
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                k = $urandom;
                h = $urandom;
            end
            else if (r < 10)
                h = $urandom;
            add_req(kind, k, h, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        logic [MAX_OCC_W-1:0] limits [7];
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // empty table, key and hash extremes, wrap, update, tombstones, clear
        add_req(REQ_GET, 32'h11, 32'h05, 64'h0);
        add_req(REQ_DEL, 32'h11, 32'h05, 64'h0);
        add_req(REQ_SET, 32'h0, 32'h0, '1);
        add_req(REQ_SET, '1, '1, 64'h0);
        add_req(REQ_SET, 32'h11, 32'hFF, 64'h0123_4567_89AB_CDEF);
        add_req(REQ_GET, 32'h11, 32'hFF, 64'h0);
        add_req(REQ_SET, 32'h0, 32'h0, 64'h5555_5555_5555_5555);
        add_req(REQ_GET, 32'h0, 32'h0, '1);
        add_req(REQ_GET, 32'h22, 32'h0, 64'h0);
        add_req(REQ_DEL, '1, '1, 64'h0);
        add_req(REQ_GET, 32'h11, 32'hFF, 64'h0);
        add_req(REQ_DEL, '1, '1, 64'h0);
        add_req(REQ_SET, 32'h33, 32'h1FF, 64'hDEAD_BEEF_0000_0001);
        add_req(REQ_GET, 32'h33, '1, 64'h0);
        add_req(REQ_CLEAR, '1, '1, '1);
        add_req(REQ_GET, 32'h0, 32'h0, 64'h0);
        add_req(REQ_SET, 32'hAAAA_AAAA, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        add_req(REQ_GET, 32'hAAAA_AAAA, 32'h5555_5555, 64'h0);

        // load limit: refusal, update and tombstone reuse are not refused
        write_limit(8'd2);
        add_req(REQ_SET, 32'h101, 32'h10, 64'h1);
        add_req(REQ_SET, 32'h102, 32'h10, 64'h2);
        add_req(REQ_SET, 32'h101, 32'h10, 64'h3);
        add_req(REQ_DEL, 32'h101, 32'h10, 64'h0);
        add_req(REQ_SET, 32'h102, 32'h10, 64'h4);
        write_limit(8'd0);
        add_req(REQ_SET, 32'h103, 32'h20, 64'h5);
        add_req(REQ_GET, 32'h102, 32'h10, 64'h0);

        limits[0] = 8'd255;
        limits[1] = 8'd1;
        limits[2] = 8'd8;
        limits[3] = MAX_OCC_RESET;
        limits[4] = 8'($urandom_range(1, 255));
        limits[5] = 8'd100;
        limits[6] = 8'($urandom_range(1, 255));
        for (int p = 0; p < 7; p++)
        begin
            write_limit(limits[p]);
            if (p == 6)
                calm = 1'b1;
            if (p % 2 == 1)
                add_req(REQ_CLEAR, $urandom, $urandom, {$urandom, $urandom});
            random_phase(245);
        end

        wait_idle();
        repeat (300) @(negedge clk);

        $display("Covered %0d requests across %0d limit writes plus the reset limit.", n_sent,
                 n_cfg);
        $display("Results: %0d done, %0d absent, %0d full, %0d new keys stored.", n_done,
                 n_absent, n_full, n_new);
        if (errors == 0 && rsp_due.size() == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", errors, rsp_due.size());
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d results outstanding", rsp_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_slot_store.sv
rtl/linear_probe_hash_table_core.sv
rtl/lpht_checker.sv
test/tb_linear_probe_hash_table_core.sv
